// File: rtl/ote_pkg.sv
// ----------------------------------------------------------------------------
// ote_pkg
// Shared constants, register indexes and the cell-to-cell link type of the
// onset triggered event table.
// ----------------------------------------------------------------------------
package ote_pkg;

  localparam int EVENT_SLOTS = 64;
  localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);

  localparam logic [31:0] MIN_GAP_US     = 32'd100;
  localparam logic [31:0] MAX_DT_US      = 32'd100000;
  localparam logic [16:0] HOLD_US        = 17'd120000;
  localparam logic [20:0] LOG2_FLOOR_Q16 = 21'd526530;
  localparam logic [15:0] MIN_STRENGTH   = 16'd263;
  // ln2 in Q16 (45426) times 10^6 / 64 (15625).
  localparam logic [29:0] LIFE_K         = 30'd709781250;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_DECAY     = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd32768;
  localparam logic [10:0] GAIN_RST      = 11'd256;
  localparam logic [11:0] DECAY_RST     = 12'd512;

  // Token that walks the cell row once per tick.
  typedef struct packed {
    logic             tok;
    logic             want;
    logic             taken;
    logic [CNT_W-1:0] active;
    logic [CNT_W-1:0] expired;
  } ote_link_t;

endpackage

// File: rtl/ote_cell.sv
// ----------------------------------------------------------------------------
// ote_cell
// One event slot: claims a pending spawn if free, checks expiry and passes
// the running counts on to the next slot.
// ----------------------------------------------------------------------------
module ote_cell import ote_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] tick_time,
  input  logic [31:0] new_life,
  input  ote_link_t   link_in,
  output ote_link_t   link_out
);

  logic        valid_r;
  logic [31:0] birth_r;
  logic [31:0] life_r;
  ote_link_t   link_r;
  ote_link_t   link_nxt;

  logic        take;
  logic        eff_valid;
  logic [31:0] cur_birth;
  logic [31:0] cur_life;
  logic [31:0] age;
  logic        expire;
  logic        keep;

  always_comb begin
    take      = link_in.tok & link_in.want & ~link_in.taken & ~valid_r;
    eff_valid = valid_r | take;
    cur_birth = take ? tick_time : birth_r;
    cur_life  = take ? new_life : life_r;
    age       = tick_time - cur_birth;
    // A negative age never expires on this tick.
    expire    = eff_valid & ~age[31] & (age >= cur_life);
    keep      = eff_valid & ~expire;

    link_nxt         = link_in;
    link_nxt.taken   = link_in.taken | take;
    link_nxt.active  = link_in.active + CNT_W'(keep);
    link_nxt.expired = link_in.expired + CNT_W'(expire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      link_r  <= '0;
    end else begin
      link_r <= link_nxt;
      if (link_in.tok) begin
        valid_r <= keep;
      end
    end
    if (take) begin
      birth_r <= tick_time;
      life_r  <= new_life;
    end
  end

  assign link_out = link_r;

endmodule

// File: rtl/ote_life.sv
// ----------------------------------------------------------------------------
// ote_life
// Lifetime of a new event: log2 by repeated squaring, a split constant
// multiply and a restoring divide by the decay rate.
// ----------------------------------------------------------------------------
module ote_life import ote_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] strength,
  input  logic [11:0] decay,
  output logic        done,
  output logic [31:0] lifetime
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOG  = 3'd1;
  localparam logic [2:0] S_MUL0 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  logic [2:0]  state_r;
  logic        done_r;
  logic [15:0] m_r;
  logic [19:0] res_r;
  logic [4:0]  cnt_r;
  logic [39:0] plo_r;
  logic [38:0] phi_r;
  logic [31:0] q_r;
  logic [11:0] rem_r;
  logic [31:0] life_r;

  logic [3:0]  msb;
  logic [15:0] m_init;
  logic [31:0] sq;
  logic [16:0] mm;
  logic [20:0] dl;
  logic        dl_pos;
  logic [48:0] acc;
  logic [12:0] rem_sh;
  logic        ge;

  always_comb begin
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (strength[i]) begin
        msb = 4'(i);
      end
    end
    m_init = 16'(strength << (4'd15 - msb));
    sq     = m_r * m_r;
    mm     = 17'(sq >> 15);
    dl     = {1'b0, res_r} - LOG2_FLOOR_Q16;
    dl_pos = ~dl[20] & (dl != 21'd0);
    acc    = {phi_r, 10'd0} + 49'(plo_r);
    rem_sh = {rem_r, q_r[31]};
    ge     = rem_sh >= {1'b0, decay};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (strength < MIN_STRENGTH) begin
              life_r <= 32'd0;
              done_r <= 1'b1;
            end else begin
              m_r     <= m_init;
              res_r   <= {msb, 16'd0};
              cnt_r   <= 5'd0;
              state_r <= S_LOG;
            end
          end
        end
        S_LOG: begin
          if (mm[16]) begin
            m_r                   <= mm[16:1];
            res_r[5'd15 - cnt_r]  <= 1'b1;
          end else begin
            m_r <= mm[15:0];
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          if (!dl_pos) begin
            life_r  <= 32'd0;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else if (decay == 12'd0) begin
            life_r  <= 32'hFFFF_FFFF;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            plo_r   <= dl[9:0] * LIFE_K;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          phi_r   <= dl[18:10] * LIFE_K;
          state_r <= S_SUM;
        end
        S_SUM: begin
          q_r     <= 32'(acc >> 18);
          rem_r   <= 12'd0;
          cnt_r   <= 5'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? 12'(rem_sh - {1'b0, decay}) : rem_sh[11:0];
          q_r   <= {q_r[30:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            life_r  <= {q_r[30:0], ge};
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign lifetime = life_r;

endmodule

// File: rtl/onset_triggered_event_table.sv
// ----------------------------------------------------------------------------
// onset_triggered_event_table
// Smooths onset levels, spawns timed events into a 64-slot table and ages
// them out.
// ----------------------------------------------------------------------------
// One tick is handled at a time. A tick inside the 100 us gap goes straight
// to the output. Any other tick walks a token along the row of slot cells,
// one cell per cycle, to claim a free slot and count expiries. A tick that
// spawns first runs the lifetime unit: 16 squaring steps of the log2,
// three multiply and add steps and a 32-step divide by the decay rate.
// A finished result is held in the output register while the next tick is
// taken in.
module onset_triggered_event_table import ote_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // time_us[31:0], onset_level[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // spawn_strength[15:0], smoothed_level[31:16],
                                  // active_count[38:32], expired_count[45:39], zeros
  output logic [2:0]  out_tuser,  // ignored[0], spawned[1], dropped_full[2]
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_CALC  = 3'd1;
  localparam logic [2:0] C_STR   = 3'd2;
  localparam logic [2:0] C_LIFE  = 3'd3;
  localparam logic [2:0] C_SWEEP = 3'd4;
  localparam logic [2:0] C_DONE  = 3'd5;

  logic [2:0]       state_r;
  logic [15:0]      thr_r;
  logic [10:0]      gain_r;
  logic [11:0]      decay_r;
  logic [31:0]      last_time_r;
  logic             first_r;
  logic [15:0]      avg_r;
  logic [16:0]      hold_r;
  logic [31:0]      t_r;
  logic [15:0]      lvl_r;
  logic             want_r;
  logic [15:0]      str_r;
  logic [CNT_W-1:0] active_r;
  logic             ign_r;
  logic             spawn_r;
  logic             drop_r;
  logic [CNT_W-1:0] exp_r;
  ote_link_t        head_r;

  logic             out_tvalid_r;
  logic [47:0]      out_tdata_r;
  logic [2:0]       out_tuser_r;

  ote_link_t        chain [0:EVENT_SLOTS];

  logic             accept;
  logic [31:0]      d;
  logic             ign;
  logic [15:0]      avg_new;
  logic [26:0]      prod;
  logic [18:0]      s_full;
  logic [15:0]      str_sat;
  logic             life_start;
  logic             life_done;
  logic [31:0]      life_val;
  logic             out_free;
  logic             out_load;
  logic             launch;
  ote_link_t        tail;

  assign in_tready = (state_r == C_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid_r | out_tready;
  assign tail      = chain[EVENT_SLOTS];
  assign chain[0]  = head_r;

  always_comb begin
    d   = in_tdata[31:0] - last_time_r;
    ign = ~first_r & ($signed(d) > -$signed(MIN_GAP_US)) & ($signed(d) < $signed(MIN_GAP_US));

    avg_new  = 16'(({1'b0, avg_r} + {1'b0, lvl_r}) >> 1);

    prod    = avg_r * gain_r;
    s_full  = prod[26:8];
    str_sat = (s_full > 19'd65535) ? 16'hFFFF : s_full[15:0];

    life_start = (state_r == C_STR) & want_r;
    launch     = ((state_r == C_STR) & ~want_r) | ((state_r == C_LIFE) & life_done);
    out_load   = (state_r == C_DONE) & out_free;
  end

  // dt is computed from the item register in the CALC state, so recompute
  // the distance there against the stored time.
  logic [31:0] dc;
  logic [16:0] dtc;
  always_comb begin
    dc = t_r - last_time_r;
    if (first_r || dc[31] || dc == 32'd0) begin
      dtc = 17'd0;
    end else if (dc > MAX_DT_US) begin
      dtc = 17'(MAX_DT_US);
    end else begin
      dtc = dc[16:0];
    end
  end

  logic [16:0] hold_calc;
  logic        want_calc;
  always_comb begin
    hold_calc = (hold_r > dtc) ? hold_r - dtc : 17'd0;
    want_calc = (hold_calc == 17'd0) && (avg_new >= thr_r);
  end

  ote_life u_life (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (life_start),
    .strength (str_sat),
    .decay    (decay_r),
    .done     (life_done),
    .lifetime (life_val)
  );

  for (genvar g = 0; g < EVENT_SLOTS; g++) begin : g_cell
    ote_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tick_time (t_r),
      .new_life  (life_val),
      .link_in   (chain[g]),
      .link_out  (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= C_IDLE;
      thr_r        <= THRESHOLD_RST;
      gain_r       <= GAIN_RST;
      decay_r      <= DECAY_RST;
      last_time_r  <= 32'd0;
      first_r      <= 1'b1;
      avg_r        <= 16'd0;
      hold_r       <= 17'd0;
      active_r     <= '0;
      head_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // The token enters the row with the spawn request of this tick.
      head_r       <= '{tok: launch, want: want_r, taken: 1'b0, active: '0, expired: '0};
      out_tvalid_r <= out_load | (out_tvalid_r & ~out_tready);
      if (cfg_wen) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r   <= cfg_wdata;
          REG_GAIN:      gain_r  <= cfg_wdata[10:0];
          REG_DECAY:     decay_r <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      case (state_r)
        C_IDLE: begin
          if (accept) begin
            t_r     <= in_tdata[31:0];
            lvl_r   <= in_tdata[47:32];
            ign_r   <= ign;
            spawn_r <= 1'b0;
            drop_r  <= 1'b0;
            exp_r   <= '0;
            state_r <= ign ? C_DONE : C_CALC;
          end
        end
        C_CALC: begin
          last_time_r <= t_r;
          first_r     <= 1'b0;
          avg_r       <= avg_new;
          hold_r      <= want_calc ? HOLD_US : hold_calc;
          want_r      <= want_calc;
          state_r     <= C_STR;
        end
        C_STR: begin
          str_r <= str_sat;
          if (!want_r) begin
            state_r <= C_SWEEP;
          end else begin
            state_r <= C_LIFE;
          end
        end
        C_LIFE: begin
          if (life_done) begin
            state_r <= C_SWEEP;
          end
        end
        C_SWEEP: begin
          if (tail.tok) begin
            spawn_r  <= want_r & tail.taken;
            drop_r   <= want_r & ~tail.taken;
            exp_r    <= tail.expired;
            active_r <= tail.active;
            state_r  <= C_DONE;
          end
        end
        C_DONE: begin
          if (out_free) begin
            out_tuser_r  <= {drop_r, spawn_r, ign_r};
            out_tdata_r  <= {2'd0, 7'(exp_r), 7'(active_r), avg_r,
                             spawn_r ? str_r : 16'd0};
            state_r      <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    tail.tok |-> state_r == C_SWEEP)
    else $error("sweep token left the row outside a sweep");

  a_life_done: assert property (@(posedge clk) disable iff (!rst_n)
    life_done |-> state_r == C_LIFE)
    else $error("lifetime finished while not waiting for it");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tuser_r[1] && (out_tuser_r[0] || out_tuser_r[2])))
    else $error("spawned result also flagged ignored or dropped");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_SWEEP && tail.tok) |=> active_r <= CNT_W'(EVENT_SLOTS))
    else $error("live count above table size");

endmodule

// File: tb/sv/tb_onset_triggered_event_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_onset_triggered_event_table
// Drives timestamped onset ticks through the event table under several
// register settings and handshake pressures. Every tick result is compared
// against a cycle-free model of smoothing, hold-off, spawning and expiry.
// ----------------------------------------------------------------------------
module tb_onset_triggered_event_table;
  import ote_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    bit        ignored;
    bit        spawned;
    bit        dropped;
    bit [15:0] strength;
    bit [15:0] smoothed;
    bit [6:0]  active;
    bit [6:0]  expired;
  } tick_result_t;

  class tick_scoreboard;
    bit [15:0]    threshold;
    bit [10:0]    gain;
    bit [11:0]    decay;
    bit [31:0]    last_time;
    bit           first_tick;
    bit [15:0]    level_avg;
    bit [16:0]    hold_left;
    bit           live[EVENT_SLOTS];
    bit [31:0]    birth[EVENT_SLOTS];
    bit [31:0]    lifetime[EVENT_SLOTS];
    tick_result_t expected_q[$];
    int           errors;

    function new();
      threshold  = THRESHOLD_RST;
      gain       = GAIN_RST;
      decay      = DECAY_RST;
      last_time  = '0;
      first_tick = 1'b1;
      level_avg  = '0;
      hold_left  = '0;
      errors     = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [15:0] val);
      case (idx)
        REG_THRESHOLD: threshold = val;
        REG_GAIN:      gain = val[10:0];
        REG_DECAY:     decay = val[11:0];
        default: ;
      endcase
    endfunction

    // Truncated log2 in Q16 by repeated squaring of the Q15 mantissa.
    function bit [31:0] log2_q16(bit [31:0] v);
      int unsigned e;
      bit [63:0]   m;
      bit [31:0]   res;
      e = 0;
      while (e < 15 && (v >> (e + 1)) != 0) e++;
      m = ({32'd0, v} << (15 - e)) & 64'hFFFF;
      if (m < 32768) m = 32768;
      res = e << 16;
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 15;
        if (m >= 65536) begin
          m = m >> 1;
          res[15 - i] = 1'b1;
        end
      end
      return res;
    endfunction

    function bit [31:0] life_of(bit [15:0] s);
      int        dl;
      bit [63:0] t;
      if (s < MIN_STRENGTH) return 0;
      dl = int'(log2_q16(s)) - 526530;
      if (dl <= 0) return 0;
      if (decay == 0) return 32'hFFFF_FFFF;
      t = ((64'(dl) * 64'd45426 * 64'd1000000) >> 24) / decay;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      return t[31:0];
    endfunction

    function void note_tick(bit [31:0] t, bit [15:0] lvl);
      tick_result_t r;
      int           d, age, slot;
      bit [31:0]    dt, s;
      int unsigned  active, expired;
      r = '{default: 0};
      active = 0;
      expired = 0;
      d = int'(t - last_time);
      if (!first_tick && d > -100 && d < 100) begin
        r.ignored = 1'b1;
        foreach (live[i]) if (live[i]) active++;
      end else begin
        if (first_tick || d <= 0) dt = 0;
        else if (d > 100000) dt = 100000;
        else dt = d;
        first_tick = 1'b0;
        last_time = t;
        level_avg = (17'(level_avg) + lvl) >> 1;
        if (hold_left > 0) hold_left = (hold_left > dt) ? hold_left - dt : 0;
        if (hold_left == 0 && level_avg >= threshold) begin
          s = (32'(level_avg) * gain) >> 8;
          if (s > 65535) s = 65535;
          slot = -1;
          for (int i = 0; i < EVENT_SLOTS; i++)
            if (!live[i]) begin
              slot = i;
              break;
            end
          if (slot >= 0) begin
            live[slot] = 1'b1;
            birth[slot] = t;
            lifetime[slot] = life_of(s[15:0]);
            r.spawned = 1'b1;
            r.strength = s[15:0];
          end else begin
            r.dropped = 1'b1;
          end
          hold_left = HOLD_US;
        end
        foreach (live[i]) begin
          if (live[i]) begin
            age = int'(t - birth[i]);
            if (age >= 0 && 32'(age) >= lifetime[i]) begin
              live[i] = 1'b0;
              expired++;
            end else begin
              active++;
            end
          end
        end
      end
      r.smoothed = level_avg;
      r.active = active[6:0];
      r.expired = expired[6:0];
      expected_q = {expected_q, r};
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result transfer with no tick outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.ignored != exp_r.ignored) begin
        $error("ignored: expected %0d, got %0d", exp_r.ignored, got.ignored); errors++;
      end
      if (got.spawned != exp_r.spawned) begin
        $error("spawned: expected %0d, got %0d", exp_r.spawned, got.spawned); errors++;
      end
      if (got.dropped != exp_r.dropped) begin
        $error("dropped_full: expected %0d, got %0d", exp_r.dropped, got.dropped); errors++;
      end
      if (got.strength != exp_r.strength) begin
        $error("spawn_strength: expected %0d, got %0d", exp_r.strength, got.strength);
        errors++;
      end
      if (got.smoothed != exp_r.smoothed) begin
        $error("smoothed_level: expected %0d, got %0d", exp_r.smoothed, got.smoothed);
        errors++;
      end
      if (got.active != exp_r.active) begin
        $error("active_count: expected %0d, got %0d", exp_r.active, got.active); errors++;
      end
      if (got.expired != exp_r.expired) begin
        $error("expired_count: expected %0d, got %0d", exp_r.expired, got.expired); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  tick_scoreboard sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          cycles = 0;
  bit [31:0]   now_us;

  onset_triggered_event_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check on each transfer, then pick the next ready level.
  always @(posedge clk) begin
    tick_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.strength = out_tdata[15:0];
      got.smoothed = out_tdata[31:16];
      got.active   = out_tdata[38:32];
      got.expired  = out_tdata[45:39];
      got.ignored  = out_tuser[0];
      got.spawned  = out_tuser[1];
      got.dropped  = out_tuser[2];
      sb.check_tick(got);
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_tick(bit [31:0] t, bit [15:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {lvl, t};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(t, lvl);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(bit [15:0] th, bit [15:0] gn, bit [15:0] dc);
    wait_idle();
    cfg_wen <= 1'b1; cfg_index <= REG_THRESHOLD; cfg_wdata <= th;
    @(posedge clk);
    cfg_index <= REG_GAIN; cfg_wdata <= gn;
    @(posedge clk);
    cfg_index <= REG_DECAY; cfg_wdata <= dc;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_reg(REG_THRESHOLD, th);
    sb.set_reg(REG_GAIN, gn);
    sb.set_reg(REG_DECAY, dc);
  endtask

  task automatic step(int delta, bit [15:0] lvl);
    now_us = now_us + delta;
    send_tick(now_us, lvl);
  endtask

  // Random tick: mostly normal spacing, with gap violations, backward steps
  // and wild jumps mixed in.
  task automatic random_tick(int min_gap, int max_gap);
    int        sel;
    bit [15:0] lvl;
    sel = $urandom_range(99);
    case ($urandom_range(3))
      0: lvl = 16'hFFFF;
      1: lvl = 16'($urandom_range(65535, 40000));
      default: lvl = 16'($urandom);
    endcase
    if (sel < 10) step($urandom_range(99), lvl);
    else if (sel < 14) step(-int'($urandom_range(99)), lvl);
    else if (sel < 17) step(-int'($urandom_range(300000, 100)), lvl);
    else if (sel < 20) begin
      now_us = $urandom;
      send_tick(now_us, lvl);
    end else step($urandom_range(max_gap, min_gap), lvl);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    now_us = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first tick at time zero, gap rule, both kinds of backward
    // time, spawn, hold-off, wrap of the timestamp.
    step(0, 16'hFFFF);
    step(50, 16'hFFFF);
    step(1000, 16'hFFFF);
    step(-50, 16'h0000);
    step(-200000, 16'h0000);
    step(100, 16'hFFFF);
    step(99, 16'hFFFF);
    step(130000, 16'hFFFF);
    step(500000, 16'h0000);
    now_us = 32'hFFFF_FFC0;
    send_tick(now_us, 16'hFFFF);
    step(200000, 16'hFFFF);
    step(20000000, 16'hAAAA);
    step(-99, 16'h5555);
    // Spawns on every tick at a zero threshold, half gain and a faster decay.
    set_regs(16'd0, 16'd128, 16'd2048);
    step(130000, 16'h0001);
    step(130000, 16'h0100);
    step(130000, 16'h0200);
    step(130000, 16'h0000);
    set_regs(16'd62259, 16'd1280, 16'd128);
    step(130000, 16'hFFFF);
    step(130000, 16'hFFFF);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(THRESHOLD_RST, GAIN_RST, DECAY_RST);
        1: set_regs(16'd0, 16'd1280, 16'd2048);
        2: set_regs(16'd62259, 16'd128, 16'd128);
        3: set_regs(16'd16384, 16'd1280, 16'd128);
        4: set_regs(16'd8000, 16'd700, 16'd1000);
        default: set_regs(16'd0, 16'd300, 16'd0);
      endcase
      send_idle_pct  = (ph == 1) ? 50 : (ph == 3 || ph == 5) ? 24 : 0;
      recv_stall_pct = (ph == 2) ? 50 : (ph == 3 || ph == 5) ? 24 : 0;
      for (int n = 0; n < 66; n++) begin
        if (ph == 4 && n == 33) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        // The table-fill phase spaces ticks just past the hold-off with long
        // lifetimes so that all slots fill and spawns get refused.
        if (ph == 3) step($urandom_range(130000, 120000), 16'($urandom_range(65535, 50000)));
        else random_tick(100, 150000);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("ticks left without a result: %0d", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ote_pkg.sv
rtl/ote_cell.sv
rtl/ote_life.sv
rtl/onset_triggered_event_table.sv
tb/sv/tb_onset_triggered_event_table.sv
